[rtl/xfec_pkg.sv]
// Shared constants, codes and control types for the XOR parity FEC sender.
// No dependencies; used by every module in rtl/ but xfec_ram.
package xfec_pkg;

    // Ring depth is set through its log2, so the slot is the low bits of seq.
    localparam int SLOT_W        = 8;
    localparam int RING_DEPTH    = 1 << SLOT_W;
    localparam int PAYLOAD_WORDS = 20;

    localparam int WIDX_W     = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
    localparam int RING_WORDS = RING_DEPTH * PAYLOAD_WORDS;
    localparam int RADDR_W    = $clog2(RING_WORDS);

    localparam int SEQ_W  = 32;
    localparam int WORD_W = 64;
    localparam int NB_W   = 4;
    localparam int CNT_W  = 5;
    localparam int GS_W   = 5;

    localparam int TDATA_IN_W  = 104;
    localparam int TDATA_OUT_W = 104;

    localparam logic [GS_W-1:0] GS_RESET = GS_W'(4);
    localparam logic [GS_W-1:0] GS_MIN   = GS_W'(2);
    localparam logic [GS_W-1:0] GS_MAX   = GS_W'(16);

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_NACK = 1'b1;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_PARITY = 2'd1,
        KIND_REPLAY = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_NCHK,
        ST_RD,
        ST_RWAIT
    } t_state;

    typedef struct packed {
        logic data_take;   // latch data item, push forwarded word
        logic nack_take;   // latch NACK seq, read tag
        logic commit;      // write parity/ring, update frame state
        logic push_par;    // push parity word with the commit
        logic rep_read;    // read next ring word for replay
        logic rep_push;    // push replayed word, advance index
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic last_frame;
        logic match;
        logic rep_last;
    } t_sts;

endpackage

[rtl/xor_fec_parity_with_replay_ring.sv]
// XOR parity FEC sender with replay ring.
// Input stream (s_axis_*): tuser = operation (0 data word, 1 NACK); tdata carries
// seq, word and word_bytes. Data words of a frame come in order, PAYLOAD_WORDS per
// frame. Output stream (m_axis_*): tuser = kind (data, parity, replay), tlast on
// the final word of a frame; tdata carries out_seq, frame_cnt and out_word.
// Config: i_cfg_we / i_cfg_wdata write group_size (clamped to 2..16), written idle.
// Timing: a data word is taken by a parity RAM read, then a read-modify-write
// of the accumulator; its forwarded copy shows on the output the cycle after
// acceptance, its parity word (last frame of a group) when the output is free.
// A NACK reads the tag RAM and then checks it; on a hit it replays PAYLOAD_WORDS
// words, each read via the ring RAM's registered read port; input is held off.
// One output register parts the sides; when the receiver stalls, work stops once
// it is full and resumes as it drains. No item is dropped.
// Reset: s_axis_tready held low; valid flags and frame counters cleared at once,
// group_size = 4; ring and parity RAMs need no clearing pass.
// Depends on xfec_pkg, xfec_ctrl, xfec_dp, xfec_ram.
module xor_fec_parity_with_replay_ring
    import xfec_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [GS_W-1:0]        i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [31:0] seq, [95:32] word, [99:96] word_bytes, [103:100] zero
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
    // [0] operation
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] out_seq, [36:32] frame_cnt, [100:37] out_word, [103:101] zero
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,
    // [1:0] kind
    output logic [1:0]             m_axis_tuser,
    output logic                   m_axis_tlast
);

    t_cmd              cmd;
    t_sts              sts;
    t_kind             kind;
    logic [SEQ_W-1:0]  out_seq;
    logic [CNT_W-1:0]  out_cnt;
    logic [WORD_W-1:0] out_word;

    xfec_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .i_in_op   (s_axis_tuser),
        .i_sts     (sts),
        .o_in_ready(s_axis_tready),
        .o_cmd     (cmd)
    );

    xfec_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_seq       (s_axis_tdata[31:0]),
        .i_word      (s_axis_tdata[95:32]),
        .i_word_bytes(s_axis_tdata[99:96]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_kind      (kind),
        .o_seq       (out_seq),
        .o_cnt       (out_cnt),
        .o_word      (out_word),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tuser = kind;
    assign m_axis_tdata = {3'b000, out_word, out_cnt, out_seq};

endmodule

[rtl/xfec_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module xfec_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/xfec_ctrl.sv]
// Sequencer for the FEC sender: item intake, parity commit and NACK replay.
// Depends on xfec_pkg; drives xfec_dp through t_cmd, watches t_sts.
module xfec_ctrl
    import xfec_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_op,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // nothing is taken while reset is held
                o_in_ready = i_rst_n && i_sts.out_free;
                if (i_rst_n && i_in_valid && i_sts.out_free) begin
                    if (i_in_op == OP_NACK) begin
                        o_cmd.nack_take = 1'b1;
                        n_state         = ST_NCHK;
                    end else begin
                        o_cmd.data_take = 1'b1;
                        n_state         = ST_ACC;
                    end
                end
            end
            ST_ACC: begin
                // parity read data is ready; a parity word needs the output slot
                if (!i_sts.last_frame) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.commit   = 1'b1;
                    o_cmd.push_par = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_NCHK: begin
                n_state = i_sts.match ? ST_RD : ST_IDLE;
            end
            ST_RD: begin
                o_cmd.rep_read = 1'b1;
                n_state        = ST_RWAIT;
            end
            ST_RWAIT: begin
                if (i_sts.out_free) begin
                    o_cmd.rep_push = 1'b1;
                    n_state        = i_sts.rep_last ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/xfec_dp.sv]
// Datapath: padding, replay ring, parity accumulator, frame counters, output reg.
// Depends on xfec_pkg and xfec_ram; commanded by xfec_ctrl.
module xfec_dp
    import xfec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [GS_W-1:0]    i_cfg_wdata,
    input  logic [SEQ_W-1:0]   i_seq,
    input  logic [WORD_W-1:0]  i_word,
    input  logic [NB_W-1:0]    i_word_bytes,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output t_kind              o_kind,
    output logic [SEQ_W-1:0]   o_seq,
    output logic [CNT_W-1:0]   o_cnt,
    output logic [WORD_W-1:0]  o_word,
    output logic               o_last
);

    logic [GS_W-1:0]       r_group_size;
    logic [SEQ_W-1:0]      r_seq;
    logic [WORD_W-1:0]     r_w;
    logic [SEQ_W-1:0]      r_base;
    logic [CNT_W-1:0]      r_fig;
    logic [WIDX_W-1:0]     r_word_index;
    logic [WIDX_W-1:0]     r_rep_idx;
    logic [RING_DEPTH-1:0] r_valid;

    logic                  r_out_valid;
    t_kind                 r_out_kind;
    logic [SEQ_W-1:0]      r_out_seq;
    logic [CNT_W-1:0]      r_out_cnt;
    logic [WORD_W-1:0]     r_out_word;
    logic                  r_out_last;

    logic [WORD_W-1:0]     pad_w;
    logic [GS_W-1:0]       gs;
    logic                  last_frame;
    logic                  is_last_word;
    logic [SLOT_W-1:0]     slot;
    logic [RADDR_W-1:0]    frame_base;
    logic [WORD_W-1:0]     par_rd;
    logic [WORD_W-1:0]     acc;
    logic [SEQ_W-1:0]      tag_rd;
    logic [WORD_W-1:0]     ring_rd;
    logic                  out_free;
    logic                  push;

    // bytes at or past word_bytes are cleared; codes above 8 keep all lanes
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            pad_w[8*b +: 8] = (NB_W'(b) < i_word_bytes) ? i_word[8*b +: 8] : 8'h00;
        end
    end

    always_comb begin
        if (r_group_size < GS_MIN) begin
            gs = GS_MIN;
        end else if (r_group_size > GS_MAX) begin
            gs = GS_MAX;
        end else begin
            gs = r_group_size;
        end
    end

    assign last_frame   = (r_fig + CNT_W'(1)) >= gs;
    assign is_last_word = (r_word_index == WIDX_W'(PAYLOAD_WORDS - 1));
    assign slot         = r_seq[SLOT_W-1:0];
    assign frame_base   = RADDR_W'(slot) * RADDR_W'(PAYLOAD_WORDS);
    assign acc          = (r_fig == '0) ? r_w : (par_rd ^ r_w);

    assign out_free = !r_out_valid || i_out_ready;
    assign push     = i_cmd.data_take || i_cmd.push_par || i_cmd.rep_push;

    assign o_sts.out_free   = out_free;
    assign o_sts.last_frame = last_frame;
    assign o_sts.match      = r_valid[slot] && (tag_rd == r_seq);
    assign o_sts.rep_last   = (r_rep_idx == WIDX_W'(PAYLOAD_WORDS - 1));

    xfec_ram #(.WIDTH(WORD_W), .DEPTH(PAYLOAD_WORDS)) u_parity (
        .i_clk  (i_clk),
        .i_we   (i_cmd.commit),
        .i_waddr(r_word_index),
        .i_wdata(acc),
        .i_re   (i_cmd.data_take),
        .i_raddr(r_word_index),
        .o_rdata(par_rd)
    );

    xfec_ram #(.WIDTH(SEQ_W), .DEPTH(RING_DEPTH)) u_tag (
        .i_clk  (i_clk),
        .i_we   (i_cmd.commit && is_last_word),
        .i_waddr(slot),
        .i_wdata(r_seq),
        .i_re   (i_cmd.nack_take),
        .i_raddr(i_seq[SLOT_W-1:0]),
        .o_rdata(tag_rd)
    );

    xfec_ram #(.WIDTH(WORD_W), .DEPTH(RING_WORDS)) u_ring (
        .i_clk  (i_clk),
        .i_we   (i_cmd.commit),
        .i_waddr(frame_base + RADDR_W'(r_word_index)),
        .i_wdata(r_w),
        .i_re   (i_cmd.rep_read),
        .i_raddr(frame_base + RADDR_W'(r_rep_idx)),
        .o_rdata(ring_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GS_RESET;
        end else if (i_cfg_we) begin
            r_group_size <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.data_take || i_cmd.nack_take) begin
            r_seq <= i_seq;
        end
        if (i_cmd.data_take) begin
            r_w <= pad_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= '0;
            r_fig        <= '0;
            r_word_index <= '0;
            r_valid      <= '0;
            r_rep_idx    <= '0;
        end else begin
            if (i_cmd.commit) begin
                if (r_word_index == '0 && r_fig == '0) begin
                    r_base <= r_seq;
                end
                if (is_last_word) begin
                    r_valid[slot] <= 1'b1;
                    r_fig         <= last_frame ? '0 : r_fig + CNT_W'(1);
                    r_word_index  <= '0;
                end else begin
                    if (r_word_index == '0) begin
                        r_valid[slot] <= 1'b0;
                    end
                    r_word_index <= r_word_index + WIDX_W'(1);
                end
            end
            if (i_cmd.nack_take) begin
                r_rep_idx <= '0;
            end else if (i_cmd.rep_push) begin
                r_rep_idx <= r_rep_idx + WIDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.data_take) begin
            r_out_kind <= KIND_DATA;
            r_out_seq  <= i_seq;
            r_out_cnt  <= '0;
            r_out_word <= pad_w;
            r_out_last <= is_last_word;
        end else if (i_cmd.push_par) begin
            r_out_kind <= KIND_PARITY;
            r_out_seq  <= r_base;
            r_out_cnt  <= r_fig + CNT_W'(1);
            r_out_word <= acc;
            r_out_last <= is_last_word;
        end else if (i_cmd.rep_push) begin
            r_out_kind <= KIND_REPLAY;
            r_out_seq  <= r_seq;
            r_out_cnt  <= '0;
            r_out_word <= ring_rd;
            r_out_last <= o_sts.rep_last;
        end else begin
            r_out_kind <= r_out_kind;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_seq       = r_out_seq;
    assign o_cnt       = r_out_cnt;
    assign o_word      = r_out_word;
    assign o_last      = r_out_last;

`ifndef SYNTHESIS
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_free)
        else $error("result pushed into a full output register");

    a_par_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_par |-> (i_cmd.commit && last_frame))
        else $error("parity word outside the last frame of a group");

    a_fig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fig < CNT_W'(16)))
        else $error("frame count ran past the largest group");

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && is_last_word) |=> (r_word_index == '0))
        else $error("word index did not wrap after the last word");
`endif

endmodule
